/* rtl/core/srst_pkg.sv */
// Shared types and constants for the stepper ramp step timer.
`default_nettype none

package srst_pkg;

   // Item opcodes
   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_STEP  = 2'd1,
      OP_BRAKE = 2'd2,
      OP_STOP  = 2'd3
   } opcode_type;

   // Motion phase reported with each result
   typedef enum logic [1:0] {
      PH_STOPPED = 2'd0,
      PH_ACCEL   = 2'd1,
      PH_CRUISE  = 2'd2,
      PH_DECEL   = 2'd3
   } phase_type;

   // Sequencer states
   typedef enum logic [3:0] {
      S_IDLE,
      S_SMUL,
      S_SDIV1,
      S_SMUL2,
      S_SDIV2,
      S_BMUL,
      S_BDIV,
      S_SCLS,
      S_RDIV1,
      S_RGO2,
      S_RDIV2,
      S_DONE
   } state_type;

   // Register map, word index on the CSR port
   localparam int CSR_AW = 5;
   localparam logic [2:0] REG_LINEAR_MODE     = 3'd0;
   localparam logic [2:0] REG_ACCEL_RATE      = 3'd1;
   localparam logic [2:0] REG_DECEL_RATE      = 3'd2;
   localparam logic [2:0] REG_FULL_RAMP_STEPS = 3'd3;
   localparam logic [2:0] REG_START_PERIOD    = 3'd4;
   localparam logic [2:0] REG_CRUISE_PERIOD   = 3'd5;

   localparam logic [15:0] RATE_RESET   = 16'd1000;
   localparam logic [31:0] PERIOD_RESET = 32'd1000;

   // Serial multiply/divide unit geometry
   localparam int MDU_QW = 48;   // quotient / product / dividend register
   localparam int MDU_DW = 34;   // divisor and remainder
   localparam int MDU_CW = 6;    // iteration counter
   localparam logic [MDU_CW-1:0] LEN_MUL  = 6'd16;
   localparam logic [MDU_CW-1:0] LEN_WIDE = 6'd48;
   localparam logic [MDU_CW-1:0] LEN_RAMP = 6'd34;

   typedef struct packed {
      logic              go;
      logic              is_div;
      logic [MDU_QW-1:0] opa;   // multiplier (low 16 bits) or left-aligned dividend
      logic [MDU_DW-1:0] opb;   // multiplicand (low 32 bits) or divisor
      logic [MDU_CW-1:0] len;
   } mdu_cmd_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [MDU_QW-1:0] quo;
      logic [MDU_DW-1:0] rmd;
   } mdu_sts_type;

endpackage

`default_nettype wire

/* rtl/core/srst_if.sv */
// Valid/ready channel interfaces for the request and response beats.
`default_nettype none

interface srst_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         opcode;
   logic signed [31:0] move_steps;

   modport source (output valid, output opcode, output move_steps, input ready);
   modport sink   (input valid, input opcode, input move_steps, output ready);
endinterface

interface srst_rsp_if;
   logic        valid;
   logic        ready;
   logic        step_issued;
   logic        direction;
   logic [31:0] step_period;
   logic [1:0]  phase;
   logic [30:0] steps_left;
   logic [30:0] stopped_remaining;

   modport source (output valid, output step_issued, output direction, output step_period,
                   output phase, output steps_left, output stopped_remaining, input ready);
   modport sink   (input valid, input step_issued, input direction, input step_period,
                   input phase, input steps_left, input stopped_remaining, output ready);
endinterface

`default_nettype wire

/* rtl/core/srst_mdu.sv */
// Bit-serial unsigned multiplier (32x16) and restoring divider (48/34), one bit per cycle.
`default_nettype none

module srst_mdu (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire srst_pkg::mdu_cmd_type cmd,
   output srst_pkg::mdu_sts_type     sts
);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic                        div_ff, div_in;
   logic [srst_pkg::MDU_QW-1:0] q_ff, q_in;
   logic [srst_pkg::MDU_DW-1:0] r_ff, r_in;
   logic [srst_pkg::MDU_DW-1:0] b_ff, b_in;
   logic [srst_pkg::MDU_CW-1:0] cnt_ff, cnt_in;
   logic [srst_pkg::MDU_DW:0]   shift_rem;
   logic [srst_pkg::MDU_DW:0]   trial;
   logic [32:0]                 mac;

   always_comb begin
      shift_rem = {r_ff, q_ff[srst_pkg::MDU_QW-1]};
      trial     = shift_rem - {1'b0, b_ff};
      mac       = {1'b0, q_ff[srst_pkg::MDU_QW-1:16]} + (q_ff[0] ? {1'b0, b_ff[31:0]} : 33'd0);

      busy_in = busy_ff;
      done_in = 1'b0;
      div_in  = div_ff;
      q_in    = q_ff;
      r_in    = r_ff;
      b_in    = b_ff;
      cnt_in  = cnt_ff;

      if (cmd.go) begin
         busy_in = 1'b1;
         div_in  = cmd.is_div;
         q_in    = cmd.opa;
         b_in    = cmd.opb;
         r_in    = '0;
         cnt_in  = cmd.len;
      end else if (busy_ff) begin
         if (div_ff) begin
            // restoring step: quotient bit enters at the bottom of q
            if (!trial[srst_pkg::MDU_DW]) begin
               r_in = trial[srst_pkg::MDU_DW-1:0];
               q_in = {q_ff[srst_pkg::MDU_QW-2:0], 1'b1};
            end else begin
               r_in = shift_rem[srst_pkg::MDU_DW-1:0];
               q_in = {q_ff[srst_pkg::MDU_QW-2:0], 1'b0};
            end
         end else begin
            // multiplier bits leave at the bottom, partial sum enters at the top
            q_in = {mac, q_ff[15:1]};
         end
         cnt_in = cnt_ff - srst_pkg::MDU_CW'(1);
         if (cnt_ff == srst_pkg::MDU_CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      div_ff <= div_in;
      q_ff   <= q_in;
      r_ff   <= r_in;
      b_ff   <= b_in;
      cnt_ff <= cnt_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign sts.quo  = q_ff;
   assign sts.rmd  = r_ff;

endmodule

`default_nettype wire

/* rtl/core/stepper_ramp_step_timer.sv */
// Stepper step-period generator for trapezoidal moves with a serial ramp unit.
//
// Request channel (req_ch): one beat per command: start, step, brake or stop,
// with a signed step count used by start. Response channel (rsp_ch): exactly
// one beat per request, in order, carrying step flag, direction, period,
// phase, steps left and the count discarded by stop.
// Registers are written over the csr_ APB port (word i at byte 4*i); the user
// must write them only while the block is idle, which the block does not
// enforce. Reads return the stored value. Stop, cruising brake, constant-speed
// start/step and any step with no steps left need no serial arithmetic. A
// linear-mode step that does not ramp also passes the classify state. A ramping
// step runs two 34-bit serial divides. A linear start runs a 16-bit multiply and
// a 48-bit divide, and a second pair when the move is short and the triangle
// split needs it. A brake while accelerating runs a multiply and a divide. The
// bit-serial multiply/divide unit does all of this arithmetic. One request is in
// work at a time; the next is taken as soon as the result sits in the output
// register, even if the receiver stalls.
// Reset clears the move state, loads register defaults and empties the
// output register.
`default_nettype none

module stepper_ramp_step_timer #(
   parameter int COUNT_WIDTH = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   srst_req_if.sink                           req_ch,
   srst_rsp_if.source                         rsp_ch,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [srst_pkg::CSR_AW-1:0]   csr_paddr,
   input  wire logic [31:0]                   csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);

   localparam logic [31:0] MaxPos = 32'((33'd1 << (COUNT_WIDTH - 1)) - 33'd1);

   // configuration
   logic        lin_ff, lin_in;
   logic [15:0] acc_cfg_ff, acc_cfg_in;
   logic [15:0] dec_cfg_ff, dec_cfg_in;
   logic [30:0] full_ff, full_in;
   logic [31:0] sper_ff, sper_in;
   logic [31:0] cper_ff, cper_in;

   // move state
   logic [31:0]            rem_ff, rem_in;
   logic [COUNT_WIDTH-1:0] done_ff, done_in;
   logic [31:0]            ramp_ff, ramp_in;
   logic [31:0]            brake_ff, brake_in;
   logic [31:0]            per_ff, per_in;
   logic [31:0]            prem_ff, prem_in;
   logic                   dir_ff, dir_in;

   // per-item
   srst_pkg::state_type state_ff, state_in;
   logic        issued_ff, issued_in;
   logic        is_step_ff, is_step_in;
   logic [31:0] period_ff, period_in;
   logic [30:0] disc_ff, disc_in;
   logic        dneg_ff, dneg_in;
   logic        nneg_ff, nneg_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic        o_issued_ff, o_issued_in;
   logic        o_dir_ff, o_dir_in;
   logic [31:0] o_period_ff, o_period_in;
   logic [1:0]  o_phase_ff, o_phase_in;
   logic [30:0] o_left_ff, o_left_in;
   logic [30:0] o_disc_ff, o_disc_in;

   srst_pkg::mdu_cmd_type mdu_cmd;
   srst_pkg::mdu_sts_type mdu_sts;

   logic                    csr_wr;
   logic [15:0]             acc;
   logic [15:0]             dec;
   logic [16:0]             acc_dec_sum;
   logic [31:0]             done_ext;
   srst_pkg::phase_type     cur_phase;
   logic [31:0]             mag;
   logic signed [34:0]      n_val;
   logic                    n_neg;
   logic [34:0]             n_abs;
   logic [33:0]             den_dec;
   logic [33:0]             den_acc;
   logic [48:0]             tri_sum;
   logic                    q_neg;
   logic [35:0]             pn_full;
   logic [33:0]             rmag;

   srst_mdu u_mdu (
      .clock (clock),
      .reset (reset),
      .cmd   (mdu_cmd),
      .sts   (mdu_sts)
   );

   // ---------------------------------------------------------------- CSR port
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      lin_in     = lin_ff;
      acc_cfg_in = acc_cfg_ff;
      dec_cfg_in = dec_cfg_ff;
      full_in    = full_ff;
      sper_in    = sper_ff;
      cper_in    = cper_ff;
      csr_prdata = '0;
      case (csr_paddr[4:2])
         srst_pkg::REG_LINEAR_MODE: begin
            csr_prdata = {31'd0, lin_ff};
            if (csr_wr) lin_in = csr_pwdata[0];
         end
         srst_pkg::REG_ACCEL_RATE: begin
            csr_prdata = {16'd0, acc_cfg_ff};
            if (csr_wr) acc_cfg_in = csr_pwdata[15:0];
         end
         srst_pkg::REG_DECEL_RATE: begin
            csr_prdata = {16'd0, dec_cfg_ff};
            if (csr_wr) dec_cfg_in = csr_pwdata[15:0];
         end
         srst_pkg::REG_FULL_RAMP_STEPS: begin
            csr_prdata = {1'b0, full_ff};
            if (csr_wr) full_in = csr_pwdata[30:0];
         end
         srst_pkg::REG_START_PERIOD: begin
            csr_prdata = sper_ff;
            if (csr_wr) sper_in = csr_pwdata;
         end
         srst_pkg::REG_CRUISE_PERIOD: begin
            csr_prdata = cper_ff;
            if (csr_wr) cper_in = csr_pwdata;
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   // ---------------------------------------------------------- shared terms
   always_comb begin
      acc         = (acc_cfg_ff == 16'd0) ? 16'd1 : acc_cfg_ff;
      dec         = (dec_cfg_ff == 16'd0) ? 16'd1 : dec_cfg_ff;
      acc_dec_sum = {1'b0, acc} + {1'b0, dec};
      done_ext    = 32'(done_ff);

      if (rem_ff == 32'd0)            cur_phase = srst_pkg::PH_STOPPED;
      else if (rem_ff <= brake_ff)    cur_phase = srst_pkg::PH_DECEL;
      else if (done_ext <= ramp_ff)   cur_phase = srst_pkg::PH_ACCEL;
      else                            cur_phase = srst_pkg::PH_CRUISE;

      mag = req_ch.move_steps[31] ? (~req_ch.move_steps + 32'd1) : req_ch.move_steps;

      // ramp numerator 2p + r and its magnitude
      n_val = $signed({2'b00, per_ff, 1'b0}) + $signed({{3{prem_ff[31]}}, prem_ff});
      n_neg = n_val[34];
      n_abs = n_neg ? (~n_val + 35'd1) : n_val;

      // |1 - 4m| while braking, 4n + 1 while accelerating
      den_dec = {rem_ff, 2'b00} - 34'd1;
      den_acc = {done_ext, 2'b01};

      tri_sum = {18'd0, full_ff} + {1'b0, mdu_sts.quo};

      q_neg   = nneg_ff ^ dneg_ff;
      pn_full = q_neg ? ({4'd0, per_ff} + {2'd0, mdu_sts.quo[33:0]})
                      : ({4'd0, per_ff} - {2'd0, mdu_sts.quo[33:0]});
      rmag    = mdu_sts.rmd;
   end

   // ------------------------------------------------------------- sequencer
   always_comb begin
      state_in   = state_ff;
      rem_in     = rem_ff;
      done_in    = done_ff;
      ramp_in    = ramp_ff;
      brake_in   = brake_ff;
      per_in     = per_ff;
      prem_in    = prem_ff;
      dir_in     = dir_ff;
      issued_in  = issued_ff;
      is_step_in = is_step_ff;
      period_in  = period_ff;
      disc_in    = disc_ff;
      dneg_in    = dneg_ff;
      nneg_in    = nneg_ff;

      rsp_valid_in = (rsp_valid_ff && !rsp_ch.ready);
      o_issued_in  = o_issued_ff;
      o_dir_in     = o_dir_ff;
      o_period_in  = o_period_ff;
      o_phase_in   = o_phase_ff;
      o_left_in    = o_left_ff;
      o_disc_in    = o_disc_ff;

      mdu_cmd        = '0;
      req_ch.ready   = 1'b0;

      case (state_ff)
         srst_pkg::S_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               issued_in  = 1'b0;
               is_step_in = 1'b0;
               period_in  = 32'd0;
               disc_in    = '0;
               state_in   = srst_pkg::S_DONE;
               case (srst_pkg::opcode_type'(req_ch.opcode))
                  srst_pkg::OP_START: begin
                     dir_in  = ~req_ch.move_steps[31];
                     rem_in  = (mag > MaxPos) ? MaxPos : mag;
                     done_in = '0;
                     prem_in = 32'd0;
                     if (lin_ff) begin
                        per_in         = sper_ff;
                        mdu_cmd.go     = 1'b1;
                        mdu_cmd.is_div = 1'b0;
                        mdu_cmd.opa    = {32'd0, acc};
                        mdu_cmd.opb    = {3'd0, full_ff};
                        mdu_cmd.len    = srst_pkg::LEN_MUL;
                        state_in       = srst_pkg::S_SMUL;
                     end else begin
                        ramp_in  = 32'd0;
                        brake_in = 32'd0;
                        per_in   = cper_ff;
                     end
                  end
                  srst_pkg::OP_STEP: begin
                     is_step_in = 1'b1;
                     if (rem_ff != 32'd0) begin
                        issued_in = 1'b1;
                        period_in = per_ff;
                        rem_in    = rem_ff - 32'd1;
                        done_in   = done_ff + COUNT_WIDTH'(1);
                        if (lin_ff) state_in = srst_pkg::S_SCLS;
                     end
                  end
                  srst_pkg::OP_BRAKE: begin
                     if (cur_phase == srst_pkg::PH_CRUISE) begin
                        rem_in = brake_ff;
                     end else if (cur_phase == srst_pkg::PH_ACCEL) begin
                        mdu_cmd.go     = 1'b1;
                        mdu_cmd.is_div = 1'b0;
                        mdu_cmd.opa    = {32'd0, acc};
                        mdu_cmd.opb    = {2'd0, done_ext};
                        mdu_cmd.len    = srst_pkg::LEN_MUL;
                        state_in       = srst_pkg::S_BMUL;
                     end
                  end
                  srst_pkg::OP_STOP: begin
                     disc_in = rem_ff[30:0];
                     rem_in  = 32'd0;
                  end
                  default: begin
                     state_in = srst_pkg::S_DONE;
                  end
               endcase
            end
         end

         // brake = ramp * accel / decel
         srst_pkg::S_SMUL: begin
            if (mdu_sts.done) begin
               mdu_cmd.go     = 1'b1;
               mdu_cmd.is_div = 1'b1;
               mdu_cmd.opa    = mdu_sts.quo;
               mdu_cmd.opb    = {18'd0, dec};
               mdu_cmd.len    = srst_pkg::LEN_WIDE;
               state_in       = srst_pkg::S_SDIV1;
            end
         end

         srst_pkg::S_SDIV1: begin
            if (mdu_sts.done) begin
               if ({17'd0, rem_ff} < tri_sum) begin
                  // short move: split into a triangle
                  mdu_cmd.go     = 1'b1;
                  mdu_cmd.is_div = 1'b0;
                  mdu_cmd.opa    = {32'd0, dec};
                  mdu_cmd.opb    = {2'd0, rem_ff};
                  mdu_cmd.len    = srst_pkg::LEN_MUL;
                  state_in       = srst_pkg::S_SMUL2;
               end else begin
                  ramp_in  = {1'b0, full_ff};
                  brake_in = mdu_sts.quo[31:0];
                  state_in = srst_pkg::S_DONE;
               end
            end
         end

         srst_pkg::S_SMUL2: begin
            if (mdu_sts.done) begin
               mdu_cmd.go     = 1'b1;
               mdu_cmd.is_div = 1'b1;
               mdu_cmd.opa    = mdu_sts.quo;
               mdu_cmd.opb    = {17'd0, acc_dec_sum};
               mdu_cmd.len    = srst_pkg::LEN_WIDE;
               state_in       = srst_pkg::S_SDIV2;
            end
         end

         srst_pkg::S_SDIV2: begin
            if (mdu_sts.done) begin
               ramp_in  = mdu_sts.quo[31:0];
               brake_in = rem_ff - mdu_sts.quo[31:0];
               state_in = srst_pkg::S_DONE;
            end
         end

         srst_pkg::S_BMUL: begin
            if (mdu_sts.done) begin
               mdu_cmd.go     = 1'b1;
               mdu_cmd.is_div = 1'b1;
               mdu_cmd.opa    = mdu_sts.quo;
               mdu_cmd.opb    = {18'd0, dec};
               mdu_cmd.len    = srst_pkg::LEN_WIDE;
               state_in       = srst_pkg::S_BDIV;
            end
         end

         srst_pkg::S_BDIV: begin
            if (mdu_sts.done) begin
               rem_in   = (mdu_sts.quo > {16'd0, MaxPos}) ? MaxPos : mdu_sts.quo[31:0];
               state_in = srst_pkg::S_DONE;
            end
         end

         // classify the step with the updated counts
         srst_pkg::S_SCLS: begin
            state_in = srst_pkg::S_DONE;
            if (rem_ff == 32'd0) begin
               state_in = srst_pkg::S_DONE;
            end else if (rem_ff <= brake_ff) begin
               dneg_in        = 1'b1;
               nneg_in        = n_neg;
               mdu_cmd.go     = 1'b1;
               mdu_cmd.is_div = 1'b1;
               mdu_cmd.opa    = {n_abs[33:0], 14'd0};
               mdu_cmd.opb    = den_dec;
               mdu_cmd.len    = srst_pkg::LEN_RAMP;
               state_in       = srst_pkg::S_RDIV1;
            end else if (done_ext < ramp_ff) begin
               dneg_in        = 1'b0;
               nneg_in        = n_neg;
               mdu_cmd.go     = 1'b1;
               mdu_cmd.is_div = 1'b1;
               mdu_cmd.opa    = {n_abs[33:0], 14'd0};
               mdu_cmd.opb    = den_acc;
               mdu_cmd.len    = srst_pkg::LEN_RAMP;
               state_in       = srst_pkg::S_RDIV1;
            end else if (done_ext == ramp_ff) begin
               // ramp end reached: jump to cruise, keep remainder
               per_in = cper_ff;
            end
         end

         srst_pkg::S_RDIV1: begin
            if (mdu_sts.done) begin
               if (pn_full[35])           per_in = 32'd0;
               else if (|pn_full[34:32])  per_in = 32'hFFFF_FFFF;
               else                       per_in = pn_full[31:0];
               state_in = srst_pkg::S_RGO2;
            end
         end

         // remainder of (2p_new + r) over the same divisor
         srst_pkg::S_RGO2: begin
            nneg_in        = n_neg;
            mdu_cmd.go     = 1'b1;
            mdu_cmd.is_div = 1'b1;
            mdu_cmd.opa    = {n_abs[33:0], 14'd0};
            mdu_cmd.opb    = dneg_ff ? den_dec : den_acc;
            mdu_cmd.len    = srst_pkg::LEN_RAMP;
            state_in       = srst_pkg::S_RDIV2;
         end

         srst_pkg::S_RDIV2: begin
            if (mdu_sts.done) begin
               if (nneg_ff) begin
                  if (rmag > 34'h0_8000_0000) prem_in = 32'h8000_0000;
                  else                        prem_in = 32'd0 - rmag[31:0];
               end else begin
                  if (rmag > 34'h0_7FFF_FFFF) prem_in = 32'h7FFF_FFFF;
                  else                        prem_in = rmag[31:0];
               end
               state_in = srst_pkg::S_DONE;
            end
         end

         srst_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               o_issued_in  = issued_ff;
               o_dir_in     = dir_ff;
               o_period_in  = is_step_ff ? period_ff : ((rem_ff != 32'd0) ? per_ff : 32'd0);
               o_phase_in   = cur_phase;
               o_left_in    = rem_ff[30:0];
               o_disc_in    = disc_ff;
               state_in     = srst_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = srst_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lin_ff       <= 1'b0;
         acc_cfg_ff   <= srst_pkg::RATE_RESET;
         dec_cfg_ff   <= srst_pkg::RATE_RESET;
         full_ff      <= '0;
         sper_ff      <= srst_pkg::PERIOD_RESET;
         cper_ff      <= srst_pkg::PERIOD_RESET;
         rem_ff       <= '0;
         done_ff      <= '0;
         ramp_ff      <= '0;
         brake_ff     <= '0;
         per_ff       <= '0;
         prem_ff      <= '0;
         dir_ff       <= 1'b0;
         state_ff     <= srst_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         lin_ff       <= lin_in;
         acc_cfg_ff   <= acc_cfg_in;
         dec_cfg_ff   <= dec_cfg_in;
         full_ff      <= full_in;
         sper_ff      <= sper_in;
         cper_ff      <= cper_in;
         rem_ff       <= rem_in;
         done_ff      <= done_in;
         ramp_ff      <= ramp_in;
         brake_ff     <= brake_in;
         per_ff       <= per_in;
         prem_ff      <= prem_in;
         dir_ff       <= dir_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      issued_ff   <= issued_in;
      is_step_ff  <= is_step_in;
      period_ff   <= period_in;
      disc_ff     <= disc_in;
      dneg_ff     <= dneg_in;
      nneg_ff     <= nneg_in;
      o_issued_ff <= o_issued_in;
      o_dir_ff    <= o_dir_in;
      o_period_ff <= o_period_in;
      o_phase_ff  <= o_phase_in;
      o_left_ff   <= o_left_in;
      o_disc_ff   <= o_disc_in;
   end

   assign rsp_ch.valid             = rsp_valid_ff;
   assign rsp_ch.step_issued       = o_issued_ff;
   assign rsp_ch.direction         = o_dir_ff;
   assign rsp_ch.step_period       = o_period_ff;
   assign rsp_ch.phase             = o_phase_ff;
   assign rsp_ch.steps_left        = o_left_ff;
   assign rsp_ch.stopped_remaining = o_disc_ff;

   // ------------------------------------------------------------ assertions
   a_mdu_go_idle: assert property (@(posedge clock) disable iff (reset)
      mdu_cmd.go |-> !mdu_sts.busy)
      else $error("serial unit launched while busy");

   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == srst_pkg::S_DONE && rsp_valid_ff && !rsp_ch.ready)
         |=> state_ff == srst_pkg::S_DONE)
      else $error("result dropped while output register was full");

   a_idle_stable: assert property (@(posedge clock) disable iff (reset)
      (state_ff == srst_pkg::S_IDLE && !req_ch.valid) |=> ($stable(per_ff) && $stable(rem_ff)))
      else $error("move state changed with no request");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == srst_pkg::S_DONE)
      else $error("response beat raised outside result stage");

endmodule

`default_nettype wire

/* bench/ramp_timer_checker.sv */
// Scoreboard for the step timer: mirrors the registers, predicts each response and compares it.

module ramp_timer_checker (
   input  wire logic                        clock,
   input  wire logic                        reset,
   srst_req_if                              req_mon,
   srst_rsp_if                              rsp_mon,
   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic [srst_pkg::CSR_AW-1:0] csr_paddr,
   input  wire logic [31:0]                 csr_pwdata,
   input  wire logic [31:0]                 csr_prdata,
   input  wire logic                        csr_pready,
   output int                               mismatches,
   output int                               outstanding,
   output int                               responses_seen
);

   localparam longint PERIOD_CEIL = 64'sd4294967295;
   localparam longint REM_HI      = 64'sd2147483647;
   localparam longint REM_LO      = -64'sd2147483648;

   typedef struct packed {
      logic                step_issued;
      logic                direction;
      logic [31:0]         step_period;
      srst_pkg::phase_type phase;
      logic [30:0]         steps_left;
      logic [30:0]         stopped_remaining;
   } step_result_type;

   step_result_type awaited_results[$];

   // register mirror
   logic        lin_mode;
   logic [15:0] acc_rate, dec_rate;
   logic [30:0] full_ramp;
   logic [31:0] start_per, cruise_per;

   // move state
   logic [31:0] steps_remaining, steps_taken, ramp_len, brake_len, cur_period;
   int          period_rem;
   logic        fwd;

   int errors, checked;

   function automatic logic [31:0] clamp_count(logic [63:0] v);
      return (v > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : v[31:0];
   endfunction

   function automatic srst_pkg::phase_type motion_phase();
      if (steps_remaining == 0) return srst_pkg::PH_STOPPED;
      if (steps_remaining <= brake_len) return srst_pkg::PH_DECEL;
      if (steps_taken <= ramp_len) return srst_pkg::PH_ACCEL;
      return srst_pkg::PH_CRUISE;
   endfunction

   // p -= (2p + r) / den, remainder carried; both truncate toward zero
   function automatic void glide_period(longint den);
      longint p, r, pn, rn;
      p = {32'd0, cur_period};
      r = period_rem;
      pn = p - (2 * p + r) / den;
      if (pn < 0) pn = 0;
      if (pn > PERIOD_CEIL) pn = PERIOD_CEIL;
      rn = (2 * pn + r) % den;
      if (rn > REM_HI) rn = REM_HI;
      if (rn < REM_LO) rn = REM_LO;
      cur_period = pn[31:0];
      period_rem = int'(rn);
   endfunction

   function automatic step_result_type advance_motion(logic [1:0] op, logic [31:0] n);
      step_result_type     res;
      logic [31:0]         mag;
      logic [63:0]         acc, dec, rs, bs;
      longint              span;
      srst_pkg::phase_type ph;
      logic                stepped;
      res = '0;
      stepped = 1'b0;
      acc = (acc_rate == 0) ? 64'd1 : {48'd0, acc_rate};
      dec = (dec_rate == 0) ? 64'd1 : {48'd0, dec_rate};
      case (srst_pkg::opcode_type'(op))
         srst_pkg::OP_START: begin
            mag = n[31] ? (~n + 32'd1) : n;
            fwd = ~n[31];
            steps_remaining = clamp_count({32'd0, mag});
            steps_taken = '0;
            period_rem = 0;
            if (lin_mode) begin
               rs = {33'd0, full_ramp};
               bs = rs * acc / dec;
               // short move: split into accel and brake only
               if ({32'd0, steps_remaining} < rs + bs) begin
                  rs = {32'd0, steps_remaining} * dec / (acc + dec);
                  bs = {32'd0, steps_remaining} - rs;
               end
               ramp_len = rs[31:0];
               brake_len = bs[31:0];
               cur_period = start_per;
            end else begin
               ramp_len = '0;
               brake_len = '0;
               cur_period = cruise_per;
            end
         end
         srst_pkg::OP_STEP: begin
            stepped = 1'b1;
            if (steps_remaining != 0) begin
               res.step_issued = 1'b1;
               res.step_period = cur_period;
               steps_remaining--;
               steps_taken++;
               if (lin_mode) begin
                  ph = motion_phase();
                  if (ph == srst_pkg::PH_ACCEL) begin
                     if (steps_taken < ramp_len) begin
                        span = {32'd0, steps_taken};
                        glide_period(4 * span + 1);
                     end else begin
                        cur_period = cruise_per;
                     end
                  end else if (ph == srst_pkg::PH_DECEL) begin
                     span = {32'd0, steps_remaining};
                     glide_period(1 - 4 * span);
                  end
               end
            end
         end
         srst_pkg::OP_BRAKE: begin
            ph = motion_phase();
            if (ph == srst_pkg::PH_CRUISE) steps_remaining = brake_len;
            else if (ph == srst_pkg::PH_ACCEL)
               steps_remaining = clamp_count({32'd0, steps_taken} * acc / dec);
         end
         srst_pkg::OP_STOP: begin
            res.stopped_remaining = steps_remaining[30:0];
            steps_remaining = '0;
         end
         default: ;
      endcase
      if (!stepped) res.step_period = (steps_remaining != 0) ? cur_period : 32'd0;
      res.direction = fwd;
      res.phase = motion_phase();
      res.steps_left = steps_remaining[30:0];
      return res;
   endfunction

   function automatic logic [31:0] csr_readback(logic [2:0] idx);
      case (idx)
         srst_pkg::REG_LINEAR_MODE:     return {31'd0, lin_mode};
         srst_pkg::REG_ACCEL_RATE:      return {16'd0, acc_rate};
         srst_pkg::REG_DECEL_RATE:      return {16'd0, dec_rate};
         srst_pkg::REG_FULL_RAMP_STEPS: return {1'b0, full_ramp};
         srst_pkg::REG_START_PERIOD:    return start_per;
         srst_pkg::REG_CRUISE_PERIOD:   return cruise_per;
         default:                       return 32'd0;
      endcase
   endfunction

   function automatic void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         errors++;
         $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      end
   endfunction

   always @(posedge clock) begin
      step_result_type want;
      logic [2:0]      idx;
      idx = csr_paddr[srst_pkg::CSR_AW-1:2];
      if (reset) begin
         lin_mode = 1'b0;
         acc_rate = srst_pkg::RATE_RESET;
         dec_rate = srst_pkg::RATE_RESET;
         full_ramp = '0;
         start_per = srst_pkg::PERIOD_RESET;
         cruise_per = srst_pkg::PERIOD_RESET;
         steps_remaining = '0;
         steps_taken = '0;
         ramp_len = '0;
         brake_len = '0;
         cur_period = '0;
         period_rem = 0;
         fwd = 1'b0;
         awaited_results.delete();
         errors = 0;
         checked = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               case (idx)
                  srst_pkg::REG_LINEAR_MODE:     lin_mode = csr_pwdata[0];
                  srst_pkg::REG_ACCEL_RATE:      acc_rate = csr_pwdata[15:0];
                  srst_pkg::REG_DECEL_RATE:      dec_rate = csr_pwdata[15:0];
                  srst_pkg::REG_FULL_RAMP_STEPS: full_ramp = csr_pwdata[30:0];
                  srst_pkg::REG_START_PERIOD:    start_per = csr_pwdata;
                  srst_pkg::REG_CRUISE_PERIOD:   cruise_per = csr_pwdata;
                  default: ;
               endcase
            end else begin
               compare_field($sformatf("register %0d readback", idx), csr_readback(idx),
                             csr_prdata);
            end
         end
         // pop before push: a response never belongs to the request taken at the same edge
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (awaited_results.size() == 0) begin
               errors++;
               $error("response beat with nothing expected");
            end else begin
               want = awaited_results.pop_front();
               checked++;
               compare_field("step_issued", want.step_issued, rsp_mon.step_issued);
               compare_field("direction", want.direction, rsp_mon.direction);
               compare_field("step_period", want.step_period, rsp_mon.step_period);
               compare_field("phase", want.phase, rsp_mon.phase);
               compare_field("steps_left", want.steps_left, rsp_mon.steps_left);
               compare_field("stopped_remaining", want.stopped_remaining,
                             rsp_mon.stopped_remaining);
            end
         end
         if (req_mon.valid && req_mon.ready)
            awaited_results.push_back(advance_motion(req_mon.opcode, req_mon.move_steps));
      end
      mismatches <= errors;
      outstanding <= awaited_results.size();
      responses_seen <= checked;
   end

endmodule

/* bench/tb_top.sv */
// Top of the step timer bench: clock, reset, register setup, request traffic and verdict.

module tb_top;

   localparam logic [2:0] REG_UNUSED = 3'd7;

   logic                        clock;
   logic                        reset;
   logic                        csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [srst_pkg::CSR_AW-1:0] csr_paddr;
   logic [31:0]                 csr_pwdata, csr_prdata;

   int gap_pct, stall_pct, beats_sent, profiles_run;
   int fail_total, open_beats, rsp_checked;

   srst_req_if req_bus();
   srst_rsp_if rsp_bus();

   stepper_ramp_step_timer dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_bus),
      .rsp_ch      (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   ramp_timer_checker chk (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .mismatches     (fail_total),
      .outstanding    (open_beats),
      .responses_seen (rsp_checked)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("tb_top: errors");
      $finish;
   end

   always @(posedge clock) rsp_bus.ready <= ($urandom_range(99) >= stall_pct);

   task automatic send_beat(srst_pkg::opcode_type op, logic [31:0] n);
      if ($urandom_range(99) < gap_pct) begin
         req_bus.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < gap_pct);
      end
      req_bus.valid <= 1'b1;
      req_bus.opcode <= op;
      req_bus.move_steps <= n;
      do @(posedge clock); while (!req_bus.ready);
      beats_sent++;
   endtask

   // hold requests back until every response is in
   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (open_beats != 0) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] idx, logic [31:0] val);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic read_all();
      for (int i = 0; i <= srst_pkg::REG_CRUISE_PERIOD; i++) begin
         csr_psel <= 1'b1;
         csr_penable <= 1'b0;
         csr_pwrite <= 1'b0;
         csr_paddr <= {i[2:0], 2'b00};
         @(posedge clock);
         csr_penable <= 1'b1;
         do @(posedge clock); while (!csr_pready);
         csr_psel <= 1'b0;
         csr_penable <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic load_profile(int k);
      logic        lin;
      logic [15:0] acc, dec;
      logic [30:0] full;
      logic [31:0] sp, cp;
      case (k)
         0:       begin lin = 1; acc = 2;     dec = 1;     full = 3;
                        sp = 40000;          cp = 4000;            end
         1:       begin lin = 1; acc = 1000;  dec = 1000;  full = 8;
                        sp = 20000;          cp = 2000;            end
         2:       begin lin = 1; acc = 65535; dec = 1;     full = 5;
                        sp = 32'hFFFF_FFFF;  cp = 1;               end
         3:       begin lin = 1; acc = 1;     dec = 65535; full = 31'h7FFF_FFFF;
                        sp = 100000;         cp = 3;               end
         4:       begin lin = 0; acc = 0;     dec = 0;     full = 0;
                        sp = 777;            cp = 777;             end
         5:       begin lin = 1; acc = 0;     dec = 3;     full = 0;
                        sp = 7;              cp = 32'hFFFF_FFFF;   end
         6:       begin lin = 1; acc = 3000;  dec = 0;     full = 10;
                        sp = 65535;          cp = 500;             end
         7:       begin lin = 0; acc = 65535; dec = 65535; full = 12;
                        sp = 1;              cp = 32'hFFFF_FFFF;   end
         default: begin lin = 1; acc = 1500;  dec = 2500;  full = 20;
                        sp = 1;              cp = 1;               end
      endcase
      csr_write(srst_pkg::REG_LINEAR_MODE, {31'd0, lin});
      csr_write(srst_pkg::REG_ACCEL_RATE, {16'd0, acc});
      csr_write(srst_pkg::REG_DECEL_RATE, {16'd0, dec});
      csr_write(srst_pkg::REG_FULL_RAMP_STEPS, {1'b0, full});
      csr_write(srst_pkg::REG_START_PERIOD, sp);
      csr_write(srst_pkg::REG_CRUISE_PERIOD, cp);
      if (k == 6) csr_write(REG_UNUSED, $urandom());
      read_all();
      profiles_run++;
   endtask

   // mostly whole moves (start then a run of steps with a brake or stop now and then),
   // the rest single random beats
   task automatic run_moves(int quota);
      int          stop_at, span, pick;
      logic [31:0] count;
      stop_at = beats_sent + quota;
      while (beats_sent < stop_at) begin
         if ($urandom_range(99) < 78) begin
            span = $urandom_range(1, 30);
            count = ($urandom_range(19) == 0) ? ($urandom() & 32'h7FFF_FFFF) : span;
            if ($urandom_range(1)) count = ~count + 32'd1;
            send_beat(srst_pkg::OP_START, count);
            repeat (span + $urandom_range(0, 2)) begin
               pick = $urandom_range(99);
               if (pick < 7) send_beat(srst_pkg::OP_BRAKE, $urandom());
               else if (pick < 10) send_beat(srst_pkg::OP_STOP, $urandom());
               else send_beat(srst_pkg::OP_STEP, $urandom());
            end
         end else begin
            send_beat(srst_pkg::opcode_type'($urandom_range(3)), $urandom());
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.opcode = srst_pkg::OP_STEP;
      req_bus.move_steps = '0;
      rsp_bus.ready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      gap_pct = 0;
      stall_pct = 0;
      beats_sent = 0;
      profiles_run = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      read_all();

      // constant speed at reset values: empty moves, extremes of the count
      send_beat(srst_pkg::OP_STEP, 32'hFFFF_FFFF);
      send_beat(srst_pkg::OP_BRAKE, 0);
      send_beat(srst_pkg::OP_STOP, 0);
      send_beat(srst_pkg::OP_START, 3);
      send_beat(srst_pkg::OP_BRAKE, 0);
      send_beat(srst_pkg::OP_START, 3);
      send_beat(srst_pkg::OP_STEP, 0);
      send_beat(srst_pkg::OP_BRAKE, 0);
      send_beat(srst_pkg::OP_START, 32'h8000_0001);
      send_beat(srst_pkg::OP_STOP, 0);
      send_beat(srst_pkg::OP_START, 32'h7FFF_FFFF);
      send_beat(srst_pkg::OP_START, 0);
      send_beat(srst_pkg::OP_STEP, 0);

      // linear ramp: full trapezoid with a cruise brake, then a short triangle move
      drain();
      load_profile(0);
      send_beat(srst_pkg::OP_START, 12);
      repeat (5) send_beat(srst_pkg::OP_STEP, 0);
      send_beat(srst_pkg::OP_BRAKE, 0);
      repeat (2) send_beat(srst_pkg::OP_STEP, 0);
      send_beat(srst_pkg::OP_START, 32'hFFFF_FFFB);
      send_beat(srst_pkg::OP_STEP, 0);
      send_beat(srst_pkg::OP_BRAKE, 0);
      send_beat(srst_pkg::OP_STEP, 0);
      send_beat(srst_pkg::OP_STOP, 0);

      for (int k = 1; k <= 8; k++) begin
         drain();
         load_profile(k);
         case ((k - 1) % 4)
            0:       begin gap_pct = 0;  stall_pct = 0;  end
            1:       begin gap_pct = 65; stall_pct = 0;  end
            2:       begin gap_pct = 0;  stall_pct = 65; end
            default: begin gap_pct = 36; stall_pct = 36; end
         endcase
         run_moves(52);
      end

      drain();
      repeat (200) @(posedge clock);
      $display("covered %0d request beats over %0d register profiles and four idle patterns",
               beats_sent, profiles_run);
      $display("%0d response beats compared field by field", rsp_checked);
      if (fail_total == 0 && open_beats == 0) $display("tb_top: clean");
      else $display("tb_top: errors");
      $finish;
   end

endmodule
